FILE: hw/rtl/euler_circuit_finder_macros.svh
// Assertion macros for the Euler circuit finder.
`ifndef EULER_CIRCUIT_FINDER_MACROS_SVH
`define EULER_CIRCUIT_FINDER_MACROS_SVH

`ifndef SYNTHESIS
`define ECF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ecf assertion failed");
`define ECF_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define ECF_ASSERT(lbl, prop)
`define ECF_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/ecf_pkg.sv
// Shared constants, types and codes of the Euler circuit finder.
package ecf_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int MAX_PATH     = MAX_VERTICES * (MAX_VERTICES + 1) / 2 + 1;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int ADDR_W       = $clog2(MAX_PATH);
  localparam int PATH_W       = $clog2(MAX_PATH + 1);
  localparam int VERT_W       = 4;
  localparam int ROW_IN_W     = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 1'b1;

  localparam logic [VERT_W-1:0] RST_VERTEX_COUNT = 4'd8;
  localparam logic [VERT_W-1:0] RST_START_VERTEX = 4'd1;

  typedef logic [MAX_VERTICES-1:0] adj_row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLEAR,
    ST_POP,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } ecf_state_e;

  typedef struct packed {
    logic              row_we;
    logic [VIDX_W-1:0] row_idx;
    adj_row_t          row_bits;
    logic              bit_clr;
    logic [VIDX_W-1:0] clr_row;
    logic [VIDX_W-1:0] clr_col;
    logic              clr_all;
  } ecf_adj_cmd_t;

  typedef struct packed {
    logic              has_nbr;
    logic [VIDX_W-1:0] nbr_idx;
  } ecf_adj_rsp_t;

endpackage

FILE: hw/rtl/euler_circuit_finder.sv
// Euler circuit finder: row loader, Hierholzer walk sequencer and path emitter.
//
// Usage: adjacency rows arrive on the input channel (in_valid_i/in_ready_o),
// one request per row, taken at once while idle. A request with last_row_i set
// stores its row and then starts the walk from start_vertex; in_ready_o stays
// low until the whole walk has been delivered.
// The walk is run by one sequencer around a single neighbor-pick unit on the
// adjacency registers: an edge step is a CHECK state (pick and clear one
// direction) then a CLEAR state (clear the other and push); a pop is a CHECK
// state (append to the path) then a POP state that takes the stack memory read.
// The path is then sent on the output channel (out_valid_o/out_ready_i) in
// forward order; each vertex comes from a registered read of the path memory
// (EMIT_RD, then EMIT_OUT), with last_o on the final vertex. There is one walk
// in flight at a time.
// A stalled receiver simply holds the current vertex; nothing is lost.
// Reset clears the adjacency store, loads vertex_count = 8 and
// start_vertex = 1 and returns to idle. The adjacency store is cleared again
// when the final vertex of a walk is taken. Config writes (cfg_we_i) take
// effect at once and are meant for idle time only.
`include "euler_circuit_finder_macros.svh"

module euler_circuit_finder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ecf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ecf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ecf_pkg::VERT_W-1:0]      row_index_i,
  input  logic [ecf_pkg::ROW_IN_W-1:0]    neighbor_bits_i,
  input  logic                            last_row_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ecf_pkg::VERT_W-1:0]      vertex_o,
  output logic                            last_o
);

  ecf_pkg::ecf_state_e              state_q, state_d;
  logic [ecf_pkg::VERT_W-1:0]       vertex_count_q, start_vertex_q;
  logic [ecf_pkg::VERT_W-1:0]       top_q, top_d;
  logic [ecf_pkg::PATH_W-1:0]       depth_q, depth_d;
  logic [ecf_pkg::PATH_W-1:0]       path_len_q, path_len_d;
  logic [ecf_pkg::ADDR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ecf_pkg::VIDX_W-1:0]       j_q, j_d;

  logic [ecf_pkg::VERT_W-1:0]       stk_mem [ecf_pkg::MAX_PATH];
  logic [ecf_pkg::VERT_W-1:0]       path_mem [ecf_pkg::MAX_PATH];
  logic [ecf_pkg::VERT_W-1:0]       stk_rd_q, path_rd_q;
  logic                             stk_we, path_we;
  logic [ecf_pkg::PATH_W-1:0]       stk_below, stk_top_slot, path_len_inc;
  logic [ecf_pkg::ADDR_W-1:0]       stk_raddr, stk_waddr;

  logic [ecf_pkg::VERT_W-1:0]       n_used;
  logic [ecf_pkg::VERT_W-1:0]       top_m1, row_m1;
  logic [ecf_pkg::VIDX_W-1:0]       top_idx;
  logic                             in_fire, row_in_range;

  ecf_pkg::ecf_adj_cmd_t            adj_cmd;
  ecf_pkg::ecf_adj_rsp_t            adj_rsp;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= ecf_pkg::RST_VERTEX_COUNT;
      start_vertex_q <= ecf_pkg::RST_START_VERTEX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ecf_pkg::CFG_VERTEX_COUNT: vertex_count_q <= cfg_data_i;
        ecf_pkg::CFG_START_VERTEX: start_vertex_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (vertex_count_q == '0) begin
      n_used = ecf_pkg::VERT_W'(1);
    end else if (vertex_count_q > ecf_pkg::VERT_W'(ecf_pkg::MAX_VERTICES)) begin
      n_used = ecf_pkg::VERT_W'(ecf_pkg::MAX_VERTICES);
    end else begin
      n_used = vertex_count_q;
    end
  end

  ecf_adj_store u_adj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (adj_cmd),
    .n_i         (n_used),
    .rd_vertex_i (top_q),
    .rsp_o       (adj_rsp)
  );

  assign in_fire      = in_valid_i && in_ready_o;
  assign row_in_range = (row_index_i != '0) &&
                        (row_index_i <= ecf_pkg::VERT_W'(ecf_pkg::MAX_VERTICES));
  assign row_m1       = row_index_i - ecf_pkg::VERT_W'(1);
  assign top_m1       = top_q - ecf_pkg::VERT_W'(1);
  assign top_idx      = top_m1[ecf_pkg::VIDX_W-1:0];
  assign stk_below    = depth_q - ecf_pkg::PATH_W'(2);
  assign stk_top_slot = depth_q - ecf_pkg::PATH_W'(1);
  assign stk_raddr    = stk_below[ecf_pkg::ADDR_W-1:0];
  assign stk_waddr    = stk_top_slot[ecf_pkg::ADDR_W-1:0];

  // sequencer
  always_comb begin
    state_d      = state_q;
    top_d        = top_q;
    depth_d      = depth_q;
    path_len_d   = path_len_q;
    rd_ptr_d     = rd_ptr_q;
    j_d          = j_q;
    stk_we       = 1'b0;
    path_we      = 1'b0;
    path_len_inc = '0;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    adj_cmd      = '0;

    unique case (state_q)
      ecf_pkg::ST_IDLE: begin
        // ready is high here, so a valid request is taken
        in_ready_o       = 1'b1;
        adj_cmd.row_we   = in_valid_i && row_in_range;
        adj_cmd.row_idx  = row_m1[ecf_pkg::VIDX_W-1:0];
        adj_cmd.row_bits = ecf_pkg::adj_row_t'(neighbor_bits_i);
        if (in_valid_i && last_row_i) begin
          top_d      = start_vertex_q;
          depth_d    = ecf_pkg::PATH_W'(1);
          path_len_d = '0;
          state_d    = ecf_pkg::ST_CHECK;
        end
      end
      ecf_pkg::ST_CHECK: begin
        if (adj_rsp.has_nbr) begin
          adj_cmd.bit_clr = 1'b1;
          adj_cmd.clr_row = top_idx;
          adj_cmd.clr_col = adj_rsp.nbr_idx;
          j_d             = adj_rsp.nbr_idx;
          state_d         = ecf_pkg::ST_CLEAR;
        end else begin
          // top is finished: append to path and pop
          path_we      = path_len_q < ecf_pkg::PATH_W'(ecf_pkg::MAX_PATH);
          path_len_inc = path_len_q + ecf_pkg::PATH_W'(path_we);
          path_len_d   = path_len_inc;
          depth_d      = stk_top_slot;
          if (depth_q == ecf_pkg::PATH_W'(1)) begin
            rd_ptr_d = ecf_pkg::ADDR_W'(path_len_inc - ecf_pkg::PATH_W'(1));
            state_d  = ecf_pkg::ST_EMIT_RD;
          end else begin
            state_d = ecf_pkg::ST_POP;
          end
        end
      end
      ecf_pkg::ST_CLEAR: begin
        adj_cmd.bit_clr = 1'b1;
        adj_cmd.clr_row = j_q;
        adj_cmd.clr_col = top_idx;
        if (depth_q < ecf_pkg::PATH_W'(ecf_pkg::MAX_PATH)) begin
          stk_we  = 1'b1;
          top_d   = ecf_pkg::VERT_W'(j_q) + ecf_pkg::VERT_W'(1);
          depth_d = depth_q + ecf_pkg::PATH_W'(1);
        end
        state_d = ecf_pkg::ST_CHECK;
      end
      ecf_pkg::ST_POP: begin
        top_d   = stk_rd_q;
        state_d = ecf_pkg::ST_CHECK;
      end
      ecf_pkg::ST_EMIT_RD: begin
        state_d = ecf_pkg::ST_EMIT_OUT;
      end
      ecf_pkg::ST_EMIT_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (rd_ptr_q == '0) begin
            adj_cmd.clr_all = 1'b1;
            path_len_d      = '0;
            state_d         = ecf_pkg::ST_IDLE;
          end else begin
            rd_ptr_d = rd_ptr_q - ecf_pkg::ADDR_W'(1);
            state_d  = ecf_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ecf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ecf_pkg::ST_IDLE;
      depth_q    <= '0;
      path_len_q <= '0;
      rd_ptr_q   <= '0;
    end else begin
      state_q    <= state_d;
      depth_q    <= depth_d;
      path_len_q <= path_len_d;
      rd_ptr_q   <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    j_q   <= j_d;
  end

  // walk stack: entries below the top, top lives in top_q
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= top_q;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (path_we) begin
      path_mem[path_len_q[ecf_pkg::ADDR_W-1:0]] <= top_q;
    end
    path_rd_q <= path_mem[rd_ptr_q];
  end

  assign vertex_o = path_rd_q;
  assign last_o   = (rd_ptr_q == '0);

  `ECF_ASSERT(a_no_accept_while_emitting, !(in_ready_o && out_valid_o))
  `ECF_ASSERT_MSG(a_depth_bounded, depth_q <= ecf_pkg::PATH_W'(ecf_pkg::MAX_PATH), "stack overflow")
  `ECF_ASSERT(a_start_blocks_input, (in_fire && last_row_i) |=> !in_ready_o)
  `ECF_ASSERT_MSG(a_last_returns_idle, (out_valid_o && out_ready_i && last_o) |=> in_ready_o, "no return to idle")

endmodule

FILE: hw/rtl/ecf_adj_store.sv
// Adjacency store with masked row read and lowest-neighbor pick.
module ecf_adj_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ecf_pkg::ecf_adj_cmd_t        cmd_i,
  input  logic [ecf_pkg::VERT_W-1:0]   n_i,
  input  logic [ecf_pkg::VERT_W-1:0]   rd_vertex_i,
  output ecf_pkg::ecf_adj_rsp_t        rsp_o
);

  ecf_pkg::adj_row_t adj_q [ecf_pkg::MAX_VERTICES];

  ecf_pkg::adj_row_t                mask;
  ecf_pkg::adj_row_t                row;
  logic                             rd_ok;
  logic [ecf_pkg::VERT_W-1:0]       rd_m1;
  logic [ecf_pkg::VIDX_W-1:0]       rd_idx;

  always_comb begin
    for (int v = 0; v < ecf_pkg::MAX_VERTICES; v++) begin
      mask[v] = (ecf_pkg::VERT_W'(v) < n_i);
    end
    rd_ok  = (rd_vertex_i != '0) && (rd_vertex_i <= n_i);
    rd_m1  = rd_vertex_i - ecf_pkg::VERT_W'(1);
    rd_idx = rd_m1[ecf_pkg::VIDX_W-1:0];
    row    = rd_ok ? (adj_q[rd_idx] & mask) : '0;
  end

  // lowest set bit wins
  always_comb begin
    rsp_o.has_nbr = |row;
    rsp_o.nbr_idx = '0;
    for (int i = ecf_pkg::MAX_VERTICES - 1; i >= 0; i--) begin
      if (row[i]) begin
        rsp_o.nbr_idx = ecf_pkg::VIDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < ecf_pkg::MAX_VERTICES; v++) begin
        adj_q[v] <= '0;
      end
    end else if (cmd_i.clr_all) begin
      for (int v = 0; v < ecf_pkg::MAX_VERTICES; v++) begin
        adj_q[v] <= '0;
      end
    end else begin
      if (cmd_i.row_we) begin
        adj_q[cmd_i.row_idx] <= cmd_i.row_bits;
      end
      if (cmd_i.bit_clr) begin
        adj_q[cmd_i.clr_row][cmd_i.clr_col] <= 1'b0;
      end
    end
  end

endmodule
